[hw/rtl/assert_macros.svh]
// assertion macros used by sorted_priority_queue
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
// types and constants of the sorted priority queue
// no dependencies
package spq_pkg;

    localparam int MODE_W    = 3;
    localparam int RANK_W    = 16;
    localparam int PAY_W     = 32;
    localparam int FIELD5_W  = 5;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT     = 3'd0,
        MODE_REMOVE     = 3'd1,
        MODE_PEEK_FRONT = 3'd2,
        MODE_PEEK_TAIL  = 3'd3,
        MODE_PURGE      = 3'd4
    } t_mode;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [PAY_W-1:0]  payload;
    } t_entry;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              clr;
        logic [RANK_W-1:0] rank;
        logic [PAY_W-1:0]  payload;
    } t_cmd;

endpackage

[hw/rtl/spq_cell.sv]
// one cell of the sorted chain: holds one entry, compares and shifts
// depends on spq_pkg
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cmd   i_cmd,
    input  spq_pkg::t_entry i_prev,
    input  logic           i_prev_take,
    input  spq_pkg::t_entry i_next,
    output spq_pkg::t_entry o_entry,
    output logic           o_take,
    output logic           o_eq
);

    logic                       r_valid;
    logic [spq_pkg::RANK_W-1:0] r_rank;
    logic [spq_pkg::PAY_W-1:0]  r_payload;
    spq_pkg::t_entry            n_entry;

    assign o_entry = '{valid: r_valid, rank: r_rank, payload: r_payload};
    assign o_take  = r_valid && (r_rank >= i_cmd.rank);
    assign o_eq    = r_valid && (r_rank == i_cmd.rank);

    always_comb begin
        n_entry = o_entry;
        if (i_cmd.clr) begin
            n_entry.valid = 1'b0;
        end else if (i_cmd.ins && !o_take) begin
            if (i_prev_take) begin
                n_entry = '{valid: 1'b1, rank: i_cmd.rank, payload: i_cmd.payload};
            end else begin
                n_entry = i_prev;
            end
        end else if (i_cmd.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank    <= n_entry.rank;
        r_payload <= n_entry.payload;
    end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// sorted priority queue: top level with the cell chain and result register
// depends on spq_pkg, spq_cell and assert_macros.svh
//
//   channel   direction  fields (tdata from bit 0 up)
//   s_axis    in         mode, new_rank, new_payload
//   m_axis    out        ok, item_rank, item_payload, entry_count, is_empty, search_cost
//
// one operation per cycle while m_axis is ready: every cell compares and shifts in the same cycle
// the result is registered and shown in the cycle after the beat is taken
// a stalled result holds s_axis off until m_axis takes it
// reset empties the queue at once, no clearing pass
`include "assert_macros.svh"

module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // mode, new_rank, new_payload, zero pad
    input  logic [spq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // ok, item_rank, item_payload, entry_count, is_empty, search_cost, zero pad
    output logic [spq_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_m_valid;
    logic [spq_pkg::M_TDATA_W-1:0] r_m_data;
    logic [spq_pkg::M_TDATA_W-1:0] n_m_data;

    logic                       w_accept;
    spq_pkg::t_mode             w_mode;
    logic [spq_pkg::RANK_W-1:0] w_rank;
    logic [spq_pkg::PAY_W-1:0]  w_payload;
    logic                       w_full;
    logic                       w_empty;
    spq_pkg::t_cmd              w_cmd;

    spq_pkg::t_entry w_entry [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_take;
    logic [DEPTH-1:0] w_eq;
    logic [DEPTH-1:0] w_tail_hot;
    logic [DEPTH-1:0] w_miss_hot;
    logic [DEPTH-1:0] w_order_ok;

    logic [CW-1:0]              w_pos;
    logic [spq_pkg::RANK_W-1:0] w_tail_rank;
    logic [spq_pkg::PAY_W-1:0]  w_tail_payload;
    logic [CW-1:0]              w_cost;

    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mode    = spq_pkg::t_mode'(i_s_axis_tdata[spq_pkg::MODE_W-1:0]);
    assign w_rank    = i_s_axis_tdata[spq_pkg::MODE_W +: spq_pkg::RANK_W];
    assign w_payload = i_s_axis_tdata[spq_pkg::MODE_W + spq_pkg::RANK_W +: spq_pkg::PAY_W];
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);

    always_comb begin
        w_cmd         = '0;
        w_cmd.rank    = w_rank;
        w_cmd.payload = w_payload;
        if (w_accept) begin
            case (w_mode)
                spq_pkg::MODE_INSERT: w_cmd.ins = !w_full;
                spq_pkg::MODE_REMOVE: w_cmd.rem = !w_empty;
                spq_pkg::MODE_PURGE:  w_cmd.clr = 1'b1;
                default:              w_cmd.ins = 1'b0;
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_pkg::t_entry w_prev;
        spq_pkg::t_entry w_next;
        logic            w_prev_take;

        if (i == 0) begin : g_head
            assign w_prev      = '0;
            assign w_prev_take = 1'b1;
            assign w_miss_hot[i] = !w_take[i];
        end else begin : g_body
            assign w_prev      = w_entry[i-1];
            assign w_prev_take = w_take[i-1];
            assign w_miss_hot[i] = !w_take[i] && w_take[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_next        = '0;
            assign w_tail_hot[i] = w_valid[i];
            assign w_order_ok[i] = 1'b1;
        end else begin : g_inner
            assign w_next        = w_entry[i+1];
            assign w_tail_hot[i] = w_valid[i] && !w_valid[i+1];
            assign w_order_ok[i] = !w_valid[i+1] || (w_entry[i].rank >= w_entry[i+1].rank);
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_prev      (w_prev),
            .i_prev_take (w_prev_take),
            .i_next      (w_next),
            .o_entry     (w_entry[i]),
            .o_take      (w_take[i]),
            .o_eq        (w_eq[i])
        );

        assign w_valid[i] = w_entry[i].valid;
    end

    always_comb begin
        w_pos          = '0;
        w_tail_rank    = '0;
        w_tail_payload = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_miss_hot[i]) begin
                w_pos = w_pos | CW'(i);
            end
            if (w_tail_hot[i]) begin
                w_tail_rank    = w_tail_rank | w_entry[i].rank;
                w_tail_payload = w_tail_payload | w_entry[i].payload;
            end
        end
    end

    always_comb begin
        if (w_empty) begin
            w_cost = CW'(1);
        end else if (|(w_valid & ~w_take)) begin
            w_cost = w_pos + CW'(1);
        end else if (|w_eq) begin
            w_cost = r_count;
        end else begin
            w_cost = CW'(1);
        end
    end

    always_comb begin
        logic                       ok;
        logic [spq_pkg::RANK_W-1:0] item_rank;
        logic [spq_pkg::PAY_W-1:0]  item_payload;
        logic [CW-1:0]              cost;
        ok           = 1'b0;
        item_rank    = '0;
        item_payload = '0;
        cost         = '0;
        n_count      = r_count;
        case (w_mode)
            spq_pkg::MODE_INSERT: begin
                if (!w_full) begin
                    ok      = 1'b1;
                    cost    = w_cost;
                    n_count = r_count + CW'(1);
                end
            end
            spq_pkg::MODE_REMOVE: begin
                if (!w_empty) begin
                    ok           = 1'b1;
                    item_rank    = w_entry[0].rank;
                    item_payload = w_entry[0].payload;
                    n_count      = r_count - CW'(1);
                end
            end
            spq_pkg::MODE_PEEK_FRONT: begin
                if (!w_empty) begin
                    ok           = 1'b1;
                    item_rank    = w_entry[0].rank;
                    item_payload = w_entry[0].payload;
                end
            end
            spq_pkg::MODE_PEEK_TAIL: begin
                if (!w_empty) begin
                    ok           = 1'b1;
                    item_rank    = w_tail_rank;
                    item_payload = w_tail_payload;
                end
            end
            spq_pkg::MODE_PURGE: begin
                ok      = !w_empty;
                n_count = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        n_m_data = {4'b0000,
                    spq_pkg::FIELD5_W'(cost),
                    (n_count == '0),
                    spq_pkg::FIELD5_W'(n_count),
                    item_payload,
                    item_rank,
                    ok};
    end

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

    // occupied cells form a prefix, match the count and are sorted; an accepted insert grows the count
    `ASSERT_CLK(a_count_match, i_clk, i_rst_n, $countones(w_valid) == r_count, "count mismatch")
    `ASSERT_CLK(a_prefix, i_clk, i_rst_n, ((w_valid + DEPTH'(1)) & w_valid) == '0, "gap in chain")
    `ASSERT_CLK(a_sorted, i_clk, i_rst_n, &w_order_ok, "chain out of order")
    `ASSERT_CLK(a_insert_grows, i_clk, i_rst_n, w_accept && w_mode == spq_pkg::MODE_INSERT && !w_full |=> r_count == $past(r_count) + CW'(1), "insert lost")

endmodule
